>>> src/flood_relay_duplicate_filter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the flooding relay duplicate filter
// Implication checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FLOOD_RELAY_DUPLICATE_FILTER_TOP_DEFINES_SVH
`define FLOOD_RELAY_DUPLICATE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define FRDF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frdf assertion failed");

// Next-cycle implication.
`define FRDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frdf assertion failed");

`else

`define FRDF_ASSERT_IMPLY(lbl, ante, cons)
`define FRDF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> src/frdf_pkg.sv
// ----------------------------------------------------------------------------
// Flooding relay package
// Shared constants, codes and interface structs of the relay filter.
// ----------------------------------------------------------------------------
package frdf_pkg;

    localparam int KEY_W = 24;

    // Command codes.
    localparam logic [1:0] CMD_RECEIVED = 2'd0;
    localparam logic [1:0] CMD_OWN      = 2'd1;
    localparam logic [1:0] CMD_BUTTON   = 2'd2;

    // Result action codes.
    localparam logic [3:0] ACT_NOT_ACCEPTED   = 4'd0;
    localparam logic [3:0] ACT_DUPLICATE      = 4'd1;
    localparam logic [3:0] ACT_FORWARD_FORM   = 4'd2;
    localparam logic [3:0] ACT_JOINED         = 4'd3;
    localparam logic [3:0] ACT_FORWARD_MEAS   = 4'd4;
    localparam logic [3:0] ACT_MEAS_DROPPED   = 4'd5;
    localparam logic [3:0] ACT_SINK_REPORT    = 4'd6;
    localparam logic [3:0] ACT_INVALID_TYPE   = 4'd7;
    localparam logic [3:0] ACT_REMEMBERED     = 4'd8;
    localparam logic [3:0] ACT_BECAME_SINK    = 4'd9;
    localparam logic [3:0] ACT_BUTTON_IGNORED = 4'd10;

    // Message types carried in payload byte 2.
    localparam logic [7:0] MSG_FORM = 8'd0;
    localparam logic [7:0] MSG_MEAS = 8'd1;

    localparam logic [7:0]  REC_MANUFACTURER = 8'hFF;
    localparam logic [4:0]  MIN_RECORD_LEN   = 5'd6;
    localparam logic [4:0]  FULL_RECORD_LEN  = 5'd16;
    localparam logic [15:0] COMPANY_RESET    = 16'hFFFF;

    // Requests from the command logic to the seen table controller.
    typedef struct packed {
        logic             start;
        logic             insert;
        logic [KEY_W-1:0] key;
    } seen_req_t;

    // Status back from the seen table controller.
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } seen_stat_t;

endpackage

>>> src/frdf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frdf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/frdf_seen_ctrl.sv
// ----------------------------------------------------------------------------
// Seen table controller
// Ring of recent triples with a linear scan that compares one entry a cycle.
// ----------------------------------------------------------------------------
`include "flood_relay_duplicate_filter_top_defines.svh"

module frdf_seen_ctrl #(
    parameter int SEEN_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  frdf_pkg::seen_req_t req,
    output frdf_pkg::seen_stat_t stat
);

    localparam int IDX_W = $clog2(SEEN_DEPTH);
    localparam int CNT_W = $clog2(SEEN_DEPTH + 1);

    logic                       active_reg, active_next;
    logic                       pend_reg, pend_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic [IDX_W-1:0]           slot_reg, slot_next;
    logic [frdf_pkg::KEY_W-1:0] key_reg, key_next;
    logic [frdf_pkg::KEY_W-1:0] rd_data;
    logic                       issue;
    logic                       match;
    logic                       finish;

    frdf_ram #(
        .WIDTH(frdf_pkg::KEY_W),
        .DEPTH(SEEN_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.insert),
        .wr_addr (slot_reg),
        .wr_data (req.key),
        .rd_en   (issue),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Reads are issued only below the fill count, so unwritten entries never reach
    // the comparator. The compare happens in the cycle after the read.
    always_comb
    begin
        issue  = active_reg && (idx_reg < fill_reg);
        match  = pend_reg && (rd_data == key_reg);
        finish = active_reg && (match || (!pend_reg && !issue));

        active_next = active_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        pend_next   = issue && !match;
        if (req.start)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            key_next    = req.key;
            pend_next   = 1'b0;
        end
        else
        begin
            if (finish)
            begin
                active_next = 1'b0;
            end
            if (issue)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end

        slot_next = slot_reg;
        fill_next = fill_reg;
        if (req.insert)
        begin
            if (slot_reg == IDX_W'(SEEN_DEPTH - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + IDX_W'(1);
            end
            if (fill_reg < CNT_W'(SEEN_DEPTH))
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            idx_reg    <= '0;
            fill_reg   <= '0;
            slot_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
            idx_reg    <= idx_next;
            fill_reg   <= fill_next;
            slot_reg   <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign stat.busy = active_reg;
    assign stat.done = finish;
    assign stat.hit  = match;

    `FRDF_ASSERT_IMPLY(a_fill_bounded, 1'b1, fill_reg <= CNT_W'(SEEN_DEPTH))
    `FRDF_ASSERT_IMPLY(a_no_insert_in_scan, req.insert, !active_reg)
    `FRDF_ASSERT_NEXT(a_scan_ends, finish && !req.start, !active_reg)

endmodule

>>> src/flood_relay_duplicate_filter_top.sv
// ----------------------------------------------------------------------------
// Flooding relay duplicate filter
// Command handling, relay decisions and result register of the relay node.
// ----------------------------------------------------------------------------
// The block takes one command transaction at a time. A received record that
// passes the type, length and company checks is looked up in the seen table
// by a scan that reads and compares one entry per clock cycle, as the table
// has a single read port; it ends at the first match or after the last entry
// below the fill count. Every other command goes straight to the decision.
// The result sits in an output register, so a new transaction is accepted
// while the previous result still waits to be taken; a decision only stalls
// when that register is still full. The seen table is a ring that overwrites
// its oldest entry once SEEN_DEPTH triples are stored. It needs no clearing
// after reset: only entries below the fill count are ever searched.
// The company code register is written through its own channel and must only
// be changed while the block is idle.
// ----------------------------------------------------------------------------
`include "flood_relay_duplicate_filter_top_defines.svh"

module flood_relay_duplicate_filter_top #(
    parameter int SEEN_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,

    // Configuration channel.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,

    // Input channel.
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [7:0]         record_type,
    input  logic [4:0]         record_len,
    input  logic [63:0]        payload_low,
    input  logic [63:0]        payload_high,
    input  logic [7:0]         own_type,
    input  logic [7:0]         own_origin,
    input  logic [7:0]         own_seq,

    // Output channel.
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         action,
    output logic [7:0]         msg_kind,
    output logic [7:0]         origin_node,
    output logic [7:0]         seq_number,
    output logic [7:0]         hops_left,
    output logic [15:0]        node_and_counter,
    output logic signed [15:0] temperature,
    output logic [15:0]        humidity_tenths,
    output logic [31:0]        time_stamp,
    output logic               joined,
    output logic               sink_role
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    frdf_pkg::seen_req_t  seen_req;
    frdf_pkg::seen_stat_t seen_stat;

    logic [15:0] company_reg;
    logic        formed_reg, formed_next;
    logic        sink_reg, sink_next;
    logic        hit_reg, hit_next;

    // Item captured at acceptance.
    logic [1:0]  cmd_reg;
    logic        accept_reg;
    logic        full_reg;
    logic [7:0]  kind_reg;
    logic [7:0]  origin_reg;
    logic [7:0]  seq_reg;
    logic [7:0]  ttl_reg;
    logic [15:0] nc_reg;
    logic [15:0] temp_reg;
    logic [15:0] hum_reg;
    logic [31:0] ts_reg;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  action_reg;
    logic [7:0]  kind_out_reg;
    logic [7:0]  origin_out_reg;
    logic [7:0]  seq_out_reg;
    logic [7:0]  hops_reg;
    logic [15:0] nc_out_reg;
    logic [15:0] temp_out_reg;
    logic [15:0] hum_out_reg;
    logic [31:0] ts_out_reg;
    logic        joined_reg;
    logic        sink_out_reg;

    logic        in_fire;
    logic        rec_ok_in;
    logic        needs_scan;
    logic        slot_free;
    logic        load_result;

    // Combinational decision.
    logic [3:0]  res_action;
    logic [7:0]  res_hops;
    logic        res_triple;
    logic        res_insert;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;

    // A received record is only looked at when it is manufacturer data of
    // sufficient length that carries our company code.
    assign rec_ok_in = (record_type == frdf_pkg::REC_MANUFACTURER)
                    && (record_len >= frdf_pkg::MIN_RECORD_LEN)
                    && (payload_low[15:0] == company_reg);
    assign needs_scan = (cmd == frdf_pkg::CMD_RECEIVED) && rec_ok_in;

    assign slot_free   = !out_valid_reg || out_ready;
    assign load_result = (state_reg == S_DECIDE) && slot_free;

    // The scan starts in the acceptance cycle with the key taken from the
    // ports; later inserts use the captured triple. Both pack the key as
    // type, origin, sequence from the top byte down.
    always_comb
    begin
        seen_req.start  = in_fire && needs_scan;
        seen_req.insert = load_result && res_insert;
        if (state_reg == S_IDLE)
        begin
            seen_req.key = {payload_low[23:16], payload_low[31:24], payload_low[39:32]};
        end
        else
        begin
            seen_req.key = {kind_reg, origin_reg, seq_reg};
        end
    end

    frdf_seen_ctrl #(
        .SEEN_DEPTH(SEEN_DEPTH)
    ) u_seen (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (seen_req),
        .stat  (seen_stat)
    );

    // Relay decision for the captured item. It also yields the flag updates,
    // which only take effect when the result is loaded.
    always_comb
    begin
        res_action  = frdf_pkg::ACT_NOT_ACCEPTED;
        res_hops    = '0;
        res_triple  = 1'b0;
        res_insert  = 1'b0;
        formed_next = formed_reg;
        sink_next   = sink_reg;

        case (cmd_reg)
            frdf_pkg::CMD_RECEIVED:
            begin
                if (accept_reg)
                begin
                    res_triple = 1'b1;
                    if (hit_reg)
                    begin
                        res_action = frdf_pkg::ACT_DUPLICATE;
                    end
                    else
                    begin
                        res_insert = 1'b1;
                        if (sink_reg)
                        begin
                            // A sink reports complete measurements and nothing else.
                            if (kind_reg != frdf_pkg::MSG_MEAS)
                            begin
                                res_action = frdf_pkg::ACT_INVALID_TYPE;
                            end
                            else if (!full_reg)
                            begin
                                res_action = frdf_pkg::ACT_MEAS_DROPPED;
                            end
                            else
                            begin
                                res_action = frdf_pkg::ACT_SINK_REPORT;
                            end
                        end
                        else if (kind_reg == frdf_pkg::MSG_FORM)
                        begin
                            // A relay joins on any new form message.
                            formed_next = 1'b1;
                            sink_next   = 1'b0;
                            if (ttl_reg != 8'd0)
                            begin
                                res_action = frdf_pkg::ACT_FORWARD_FORM;
                                res_hops   = ttl_reg - 8'd1;
                            end
                            else
                            begin
                                res_action = frdf_pkg::ACT_JOINED;
                            end
                        end
                        else if (kind_reg == frdf_pkg::MSG_MEAS)
                        begin
                            if (!full_reg || (ttl_reg == 8'd0))
                            begin
                                res_action = frdf_pkg::ACT_MEAS_DROPPED;
                            end
                            else
                            begin
                                res_action = frdf_pkg::ACT_FORWARD_MEAS;
                                res_hops   = ttl_reg - 8'd1;
                            end
                        end
                        else
                        begin
                            res_action = frdf_pkg::ACT_INVALID_TYPE;
                        end
                    end
                end
            end
            frdf_pkg::CMD_OWN:
            begin
                // Own packets are stored even when already present.
                res_insert = 1'b1;
                res_triple = 1'b1;
                res_action = frdf_pkg::ACT_REMEMBERED;
            end
            frdf_pkg::CMD_BUTTON:
            begin
                if (!formed_reg)
                begin
                    formed_next = 1'b1;
                    sink_next   = 1'b1;
                    res_action  = frdf_pkg::ACT_BECAME_SINK;
                end
                else
                begin
                    res_action = frdf_pkg::ACT_BUTTON_IGNORED;
                end
            end
            default:
            begin
                res_action = frdf_pkg::ACT_NOT_ACCEPTED;
            end
        endcase
    end

    // Sequencer: idle, table scan for records that need one, then decision
    // once the result register has room.
    always_comb
    begin
        state_next = state_reg;
        hit_next   = hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    hit_next = 1'b0;
                    if (needs_scan)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_SCAN:
            begin
                if (seen_stat.done)
                begin
                    hit_next   = seen_stat.hit;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            company_reg   <= frdf_pkg::COMPANY_RESET;
            formed_reg    <= 1'b0;
            sink_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                company_reg <= cfg_data;
            end
            if (load_result)
            begin
                formed_reg <= formed_next;
                sink_reg   <= sink_next;
            end
        end
    end

    // Captured item fields. The triple comes from the own-packet fields for
    // the remember command and from payload bytes 2-4 otherwise.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= cmd;
            accept_reg <= rec_ok_in;
            full_reg   <= (record_len >= frdf_pkg::FULL_RECORD_LEN);
            ttl_reg    <= payload_low[47:40];
            nc_reg     <= payload_low[63:48];
            temp_reg   <= payload_high[15:0];
            hum_reg    <= payload_high[31:16];
            ts_reg     <= payload_high[63:32];
            if (cmd == frdf_pkg::CMD_OWN)
            begin
                kind_reg   <= own_type;
                origin_reg <= own_origin;
                seq_reg    <= own_seq;
            end
            else
            begin
                kind_reg   <= payload_low[23:16];
                origin_reg <= payload_low[31:24];
                seq_reg    <= payload_low[39:32];
            end
        end
    end

    // Result register. Measurement fields appear only on a forwarded
    // measurement or a sink report.
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            action_reg     <= res_action;
            hops_reg       <= res_hops;
            kind_out_reg   <= res_triple ? kind_reg : 8'd0;
            origin_out_reg <= res_triple ? origin_reg : 8'd0;
            seq_out_reg    <= res_triple ? seq_reg : 8'd0;
            joined_reg     <= formed_next;
            sink_out_reg   <= sink_next;
            if ((res_action == frdf_pkg::ACT_FORWARD_MEAS)
                || (res_action == frdf_pkg::ACT_SINK_REPORT))
            begin
                nc_out_reg   <= nc_reg;
                temp_out_reg <= temp_reg;
                hum_out_reg  <= hum_reg;
                ts_out_reg   <= ts_reg;
            end
            else
            begin
                nc_out_reg   <= '0;
                temp_out_reg <= '0;
                hum_out_reg  <= '0;
                ts_out_reg   <= '0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign action           = action_reg;
    assign msg_kind         = kind_out_reg;
    assign origin_node      = origin_out_reg;
    assign seq_number       = seq_out_reg;
    assign hops_left        = hops_reg;
    assign node_and_counter = nc_out_reg;
    assign temperature      = signed'(temp_out_reg);
    assign humidity_tenths  = hum_out_reg;
    assign time_stamp       = ts_out_reg;
    assign joined           = joined_reg;
    assign sink_role        = sink_out_reg;

    `FRDF_ASSERT_IMPLY(a_scan_busy, state_reg == S_SCAN, seen_stat.busy)
    `FRDF_ASSERT_NEXT(a_scan_to_decide, (state_reg == S_SCAN) && seen_stat.done, state_reg == S_DECIDE)
    `FRDF_ASSERT_IMPLY(a_result_from_decide, $rose(out_valid_reg), $past(state_reg == S_DECIDE))

endmodule

>>> tb/relay_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Relay filter checking package
// Command and result records plus the outcome checker of the relay testbench.
// ----------------------------------------------------------------------------
package relay_check_pkg;

    import frdf_pkg::*;

    localparam int SEEN_SLOTS = 256;

    // The command field has one code that the block does not use.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  record_type;
        logic [4:0]  record_len;
        logic [63:0] payload_low;
        logic [63:0] payload_high;
        logic [7:0]  own_type;
        logic [7:0]  own_origin;
        logic [7:0]  own_seq;
    } relay_cmd_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  msg_kind;
        logic [7:0]  origin_node;
        logic [7:0]  seq_number;
        logic [7:0]  hops_left;
        logic [15:0] node_and_counter;
        logic [15:0] temperature;
        logic [15:0] humidity_tenths;
        logic [31:0] time_stamp;
        logic        joined;
        logic        sink_role;
    } relay_outcome_t;

    class relay_outcome_checker;

        logic [KEY_W-1:0] seen_ring [SEEN_SLOTS];
        int unsigned      ring_slot;
        int unsigned      ring_fill;
        int unsigned      ring_writes;
        bit               net_formed;
        bit               is_sink;
        logic [15:0]      expected_company;
        relay_outcome_t   pending_outcomes[$];
        int unsigned      bad_outcomes;
        int unsigned      outcomes_checked;
        bit [15:0]        actions_seen;

        function new();
            expected_company = COMPANY_RESET;
            ring_slot        = 0;
            ring_fill        = 0;
            ring_writes      = 0;
            net_formed       = 1'b0;
            is_sink          = 1'b0;
            bad_outcomes     = 0;
            outcomes_checked = 0;
            actions_seen     = '0;
        endfunction

        function void set_company(logic [15:0] code);
            expected_company = code;
        endfunction

        // Once the ring is full the oldest triple is overwritten.
        function void record_triple(logic [KEY_W-1:0] key);
            seen_ring[ring_slot] = key;
            ring_slot = (ring_slot + 1) % SEEN_SLOTS;
            if (ring_fill < SEEN_SLOTS)
                ring_fill++;
            ring_writes++;
        endfunction

        // Works out the result of one accepted command and queues it.
        function void note_command(relay_cmd_t c);
            relay_outcome_t r;
            logic [7:0]       kind;
            logic [7:0]       origin;
            logic [7:0]       seq;
            logic [7:0]       ttl;
            logic [KEY_W-1:0] key;
            bit               hit;
            bit               full;
            r      = '0;
            kind   = c.payload_low[23:16];
            origin = c.payload_low[31:24];
            seq    = c.payload_low[39:32];
            ttl    = c.payload_low[47:40];
            key    = {kind, origin, seq};
            case (c.cmd)
                CMD_RECEIVED:
                begin
                    if (c.record_type == REC_MANUFACTURER && c.record_len >= MIN_RECORD_LEN
                        && c.payload_low[15:0] == expected_company)
                    begin
                        r.msg_kind    = kind;
                        r.origin_node = origin;
                        r.seq_number  = seq;
                        hit = 1'b0;
                        for (int i = 0; i < ring_fill; i++)
                            if (seen_ring[i] == key)
                                hit = 1'b1;
                        if (hit)
                        begin
                            r.action = ACT_DUPLICATE;
                        end
                        else
                        begin
                            full = c.record_len >= FULL_RECORD_LEN;
                            record_triple(key);
                            if (is_sink)
                            begin
                                if (kind != MSG_MEAS)
                                    r.action = ACT_INVALID_TYPE;
                                else if (!full)
                                    r.action = ACT_MEAS_DROPPED;
                                else
                                    r.action = ACT_SINK_REPORT;
                            end
                            else if (kind == MSG_FORM)
                            begin
                                net_formed = 1'b1;
                                if (ttl != 0)
                                begin
                                    r.action    = ACT_FORWARD_FORM;
                                    r.hops_left = ttl - 8'd1;
                                end
                                else
                                begin
                                    r.action = ACT_JOINED;
                                end
                            end
                            else if (kind == MSG_MEAS)
                            begin
                                if (!full || ttl == 0)
                                begin
                                    r.action = ACT_MEAS_DROPPED;
                                end
                                else
                                begin
                                    r.action    = ACT_FORWARD_MEAS;
                                    r.hops_left = ttl - 8'd1;
                                end
                            end
                            else
                            begin
                                r.action = ACT_INVALID_TYPE;
                            end
                            if (r.action == ACT_FORWARD_MEAS || r.action == ACT_SINK_REPORT)
                            begin
                                r.node_and_counter = c.payload_low[63:48];
                                r.temperature      = c.payload_high[15:0];
                                r.humidity_tenths  = c.payload_high[31:16];
                                r.time_stamp       = c.payload_high[63:32];
                            end
                        end
                    end
                end
                CMD_OWN:
                begin
                    record_triple({c.own_type, c.own_origin, c.own_seq});
                    r.action      = ACT_REMEMBERED;
                    r.msg_kind    = c.own_type;
                    r.origin_node = c.own_origin;
                    r.seq_number  = c.own_seq;
                end
                CMD_BUTTON:
                begin
                    if (!net_formed)
                    begin
                        net_formed = 1'b1;
                        is_sink    = 1'b1;
                        r.action   = ACT_BECAME_SINK;
                    end
                    else
                    begin
                        r.action = ACT_BUTTON_IGNORED;
                    end
                end
                default: r.action = ACT_NOT_ACCEPTED;
            endcase
            r.joined    = net_formed;
            r.sink_role = is_sink;
            pending_outcomes.push_back(r);
        endfunction

        function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                if (bad_outcomes < 10)
                    $display("ERROR: result %0d field %s expected 0x%0h, got 0x%0h",
                             outcomes_checked, name, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_outcome(relay_outcome_t got);
            relay_outcome_t want;
            bit             differs;
            if (pending_outcomes.size() == 0)
            begin
                if (bad_outcomes < 10)
                    $display("ERROR: result with action %0d arrived with nothing expected",
                             got.action);
                bad_outcomes++;
                return;
            end
            want = pending_outcomes.pop_front();
            outcomes_checked++;
            actions_seen[want.action] = 1'b1;
            differs = 1'b0;
            differs |= field_differs("action", want.action, got.action);
            differs |= field_differs("msg_kind", want.msg_kind, got.msg_kind);
            differs |= field_differs("origin_node", want.origin_node, got.origin_node);
            differs |= field_differs("seq_number", want.seq_number, got.seq_number);
            differs |= field_differs("hops_left", want.hops_left, got.hops_left);
            differs |= field_differs("node_and_counter", want.node_and_counter,
                                     got.node_and_counter);
            differs |= field_differs("temperature", want.temperature, got.temperature);
            differs |= field_differs("humidity_tenths", want.humidity_tenths,
                                     got.humidity_tenths);
            differs |= field_differs("time_stamp", want.time_stamp, got.time_stamp);
            differs |= field_differs("joined", want.joined, got.joined);
            differs |= field_differs("sink_role", want.sink_role, got.sink_role);
            if (differs)
                bad_outcomes++;
        endfunction

    endclass

endpackage

>>> tb/tb_flood_relay_duplicate_filter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flooding relay duplicate filter testbench
// Drives commands with random gaps and stalls and checks every result against
// a behavioral prediction of the relay, its seen ring and its role flags.
// ----------------------------------------------------------------------------
module tb_flood_relay_duplicate_filter_top;

    import frdf_pkg::*;
    import relay_check_pkg::*;

    // The longest quiet stretch of a correct run is a long sender gap, a full
    // seen table scan and a long receiver stall. The limit leaves a wide margin
    // over that stretch and over the end of run pause.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int ITEMS_PER_CODE = 250;
    localparam int RECENT_KEEP    = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd          = '0;
    logic [7:0]  record_type  = '0;
    logic [4:0]  record_len   = '0;
    logic [63:0] payload_low  = '0;
    logic [63:0] payload_high = '0;
    logic [7:0]  own_type     = '0;
    logic [7:0]  own_origin   = '0;
    logic [7:0]  own_seq      = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         action;
    logic [7:0]         msg_kind;
    logic [7:0]         origin_node;
    logic [7:0]         seq_number;
    logic [7:0]         hops_left;
    logic [15:0]        node_and_counter;
    logic signed [15:0] temperature;
    logic [15:0]        humidity_tenths;
    logic [31:0]        time_stamp;
    logic               joined;
    logic               sink_role;

    relay_outcome_checker board;
    relay_outcome_t       got_outcome;

    // Company code that the stimulus currently builds valid records with.
    logic [15:0] company_now = COMPANY_RESET;

    // Triples sent recently; replaying them produces duplicates, and replaying
    // old ones checks that the ring really forgot what it overwrote.
    logic [KEY_W-1:0] recent_keys[$];

    // While calm is set neither side inserts gaps or stalls.
    bit calm = 1'b0;
    int calm_timer = 0;
    int stall_left = 0;
    int idle_cycles;

    flood_relay_duplicate_filter_top #(
        .SEEN_DEPTH(SEEN_SLOTS)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .record_type      (record_type),
        .record_len       (record_len),
        .payload_low      (payload_low),
        .payload_high     (payload_high),
        .own_type         (own_type),
        .own_origin       (own_origin),
        .own_seq          (own_seq),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .action           (action),
        .msg_kind         (msg_kind),
        .origin_node      (origin_node),
        .seq_number       (seq_number),
        .hops_left        (hops_left),
        .node_and_counter (node_and_counter),
        .temperature      (temperature),
        .humidity_tenths  (humidity_tenths),
        .time_stamp       (time_stamp),
        .joined           (joined),
        .sink_role        (sink_role)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap and stall lengths: mostly short, sometimes medium, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    // A manufacturer record that passes the type, length and company checks.
    // Bytes 6 to 15 carry random measurement data.
    function automatic relay_cmd_t make_record(input logic [7:0] kind, input logic [7:0] origin,
                                               input logic [7:0] seq, input logic [7:0] ttl,
                                               input logic [4:0] len);
        relay_cmd_t c;
        c.cmd          = CMD_RECEIVED;
        c.record_type  = REC_MANUFACTURER;
        c.record_len   = len;
        c.payload_low  = {16'($urandom), ttl, seq, origin, kind, company_now};
        c.payload_high = {$urandom, $urandom};
        c.own_type     = 8'($urandom);
        c.own_origin   = 8'($urandom);
        c.own_seq      = 8'($urandom);
        return c;
    endfunction

    // Picks a triple: a replay from the history, or a fresh one drawn mostly
    // from a narrow range of origins and sequences so that collisions happen.
    function automatic logic [KEY_W-1:0] pick_triple();
        logic [7:0] kind;
        logic [7:0] origin;
        logic [7:0] seq;
        int         r;
        if (recent_keys.size() != 0 && $urandom_range(0, 3) == 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        r = $urandom_range(0, 9);
        if (r < 4)
            kind = MSG_FORM;
        else if (r < 8)
            kind = MSG_MEAS;
        else
            kind = 8'($urandom);
        origin = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        seq    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        return {kind, origin, seq};
    endfunction

    // Mostly well-formed records and own packets, with some button presses,
    // the unused command and records broken in one way or another.
    task automatic make_random_cmd(output relay_cmd_t c);
        int               pick;
        logic [KEY_W-1:0] key;
        logic [7:0]       ttl;
        logic [4:0]       len;
        pick = $urandom_range(0, 99);
        key  = pick_triple();
        ttl  = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        len  = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(16, 31))
                                           : 5'($urandom_range(6, 15));
        c = make_record(key[23:16], key[15:8], key[7:0], ttl, len);
        c.payload_high = {$urandom, $urandom};
        if (pick < 68) begin
            // Already a valid record.
        end else if (pick < 80) begin
            c.cmd        = CMD_OWN;
            c.own_type   = key[23:16];
            c.own_origin = key[15:8];
            c.own_seq    = key[7:0];
        end else if (pick < 84) begin
            c.cmd = CMD_BUTTON;
        end else if (pick < 88) begin
            c.cmd = CMD_UNUSED;
        end else begin
            case ($urandom_range(0, 3))
                0: c.record_type = 8'($urandom_range(0, 254));
                1: c.record_len  = 5'($urandom_range(0, 5));
                2: c.payload_low[15:0] = company_now ^ 16'($urandom_range(1, 65535));
                default:
                begin
                    c.record_type = 8'($urandom);
                    c.record_len  = 5'($urandom);
                    c.payload_low = {$urandom, $urandom};
                end
            endcase
        end
        if (pick < 80) begin
            recent_keys.push_back(key);
            if (recent_keys.size() > RECENT_KEEP)
                void'(recent_keys.pop_front());
        end
    endtask

    // Presents one command and returns at the edge that accepted it. With no
    // gap the valid stays high and only the payload changes.
    task automatic send_cmd(input relay_cmd_t c);
        int gap;
        gap = (calm || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c.cmd;
        record_type  <= c.record_type;
        record_len   <= c.record_len;
        payload_low  <= c.payload_low;
        payload_high <= c.payload_high;
        own_type     <= c.own_type;
        own_origin   <= c.own_origin;
        own_seq      <= c.own_seq;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_command(c);
    endtask

    // The company code only changes once every result has been taken, so the
    // block is idle; a short pause covers its last internal cycles.
    task automatic write_company(input logic [15:0] code);
        in_valid <= 1'b0;
        while (board.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_company(code);
        company_now = code;
    endtask

    // Switches between calm stretches and stretches with gaps and stalls.
    always @(posedge clk)
    begin
        if (calm_timer == 0)
        begin
            calm       <= ($urandom_range(0, 3) == 0);
            calm_timer <= $urandom_range(200, 800);
        end
        else
        begin
            calm_timer <= calm_timer - 1;
        end
    end

    // Result side: every transaction that leaves the block is checked, and
    // the ready is dropped now and then for a random number of cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_outcome.action           = action;
                got_outcome.msg_kind         = msg_kind;
                got_outcome.origin_node      = origin_node;
                got_outcome.seq_number       = seq_number;
                got_outcome.hops_left        = hops_left;
                got_outcome.node_and_counter = node_and_counter;
                got_outcome.temperature      = temperature;
                got_outcome.humidity_tenths  = humidity_tenths;
                got_outcome.time_stamp       = time_stamp;
                got_outcome.joined           = joined;
                got_outcome.sink_role        = sink_role;
                board.check_outcome(got_outcome);
            end
            if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transaction of any channel completes
    // for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        relay_cmd_t  c;
        bit          sink_run;
        logic [15:0] codes [4];

        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the company code left at its reset value.
        // A measurement with every other field at its top value is forwarded.
        c = make_record(MSG_MEAS, 8'hFF, 8'hFF, 8'hFF, 5'd31);
        c.payload_low[63:48] = '1;
        c.payload_high       = '1;
        send_cmd(c);
        // The same triple again is a duplicate, whatever the rest says.
        send_cmd(make_record(MSG_MEAS, 8'hFF, 8'hFF, 8'h03, 5'd16));
        // A short measurement and one with no hops left are both dropped.
        send_cmd(make_record(MSG_MEAS, 8'd1, 8'd1, 8'd5, 5'd15));
        send_cmd(make_record(MSG_MEAS, 8'd1, 8'd2, 8'd0, 5'd16));
        // The last hop: forwarded with zero left and all-zero data.
        c = make_record(MSG_MEAS, 8'd1, 8'd3, 8'd1, 5'd16);
        c.payload_low[63:48] = '0;
        c.payload_high       = '0;
        send_cmd(c);
        // Message types other than form and measurement.
        send_cmd(make_record(8'd2, 8'd1, 8'd4, 8'd9, 5'd16));
        send_cmd(make_record(8'hFF, 8'd1, 8'd5, 8'd9, 5'd31));
        // Records that fail the type, length and company checks.
        c = make_record(MSG_MEAS, 8'd2, 8'd1, 8'd9, 5'd16);
        c.record_type = 8'hFE;
        send_cmd(c);
        c.record_type = REC_MANUFACTURER;
        c.record_len  = 5'd5;
        send_cmd(c);
        c.record_len        = 5'd16;
        c.payload_low[15:0] = 16'hFFFE;
        send_cmd(c);
        c = '0;
        send_cmd(c);
        // The shortest record that is still accepted.
        send_cmd(make_record(MSG_MEAS, 8'd2, 8'd1, 8'd9, 5'd6));
        // An own packet is recorded twice, then a received copy is dropped.
        c     = '0;
        c.cmd = CMD_OWN;
        send_cmd(c);
        send_cmd(c);
        send_cmd(make_record(MSG_FORM, 8'd0, 8'd0, 8'd7, 5'd6));
        // The unused command with every other field high.
        c     = '1;
        c.cmd = CMD_UNUSED;
        send_cmd(c);

        // Only one role can be reached after reset, so the seed chooses it.
        sink_run = ($urandom_range(0, 1) == 1);
        c        = '0;
        c.cmd    = CMD_BUTTON;
        if (sink_run)
        begin
            // The first press makes a sink; the second is ignored.
            send_cmd(c);
            send_cmd(c);
            send_cmd(make_record(MSG_MEAS, 8'd3, 8'd1, 8'd40, 5'd20));
            send_cmd(make_record(MSG_MEAS, 8'd3, 8'd2, 8'd40, 5'd10));
            send_cmd(make_record(MSG_FORM, 8'd3, 8'd3, 8'd5, 5'd16));
            send_cmd(make_record(MSG_MEAS, 8'd3, 8'd1, 8'd40, 5'd20));
        end
        else
        begin
            // Join without forwarding, forward a form, then ignore the button.
            send_cmd(make_record(MSG_FORM, 8'd4, 8'd1, 8'd0, 5'd16));
            send_cmd(make_record(MSG_FORM, 8'd4, 8'd2, 8'hFF, 5'd31));
            send_cmd(c);
            send_cmd(make_record(MSG_MEAS, 8'd4, 8'd3, 8'd8, 5'd16));
            send_cmd(make_record(MSG_FORM, 8'd4, 8'd4, 8'd1, 5'd6));
        end

        // Random part under four company codes, the two extremes among them.
        codes[0] = 16'h0000;
        codes[1] = 16'($urandom);
        codes[2] = 16'hFFFF;
        codes[3] = 16'($urandom);
        foreach (codes[k])
        begin
            write_company(codes[k]);
            repeat (ITEMS_PER_CODE)
            begin
                make_random_cmd(c);
                send_cmd(c);
            end
        end

        in_valid <= 1'b0;
        while (board.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results under the reset company code and four written ones; %0d of 11 action codes seen.",
                 board.outcomes_checked, $countones(board.actions_seen));
        $display("The seen ring took %0d writes, wrapping %0d times; the node ran as a %s.",
                 board.ring_writes, board.ring_writes / SEEN_SLOTS,
                 sink_run ? "sink" : "relay");
        if (board.bad_outcomes == 0 && board.pending_outcomes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/frdf_pkg.sv
src/frdf_ram.sv
src/frdf_seen_ctrl.sv
src/flood_relay_duplicate_filter_top.sv
tb/relay_check_pkg.sv
tb/tb_flood_relay_duplicate_filter_top.sv
